### rtl/pmb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmb_pkg
// Shared constants and types for the phrase match bracketer.
// ----------------------------------------------------------------------------
package pmb_pkg;

  localparam int PATTERN_W = 64;
  localparam int LENGTH_W  = 4;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] OPEN_BYTE  = 8'h28;
  localparam logic [BYTE_W-1:0] CLOSE_BYTE = 8'h29;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES  = 1'b0,
    REG_PATTERN_LENGTH = 1'b1
  } cfg_reg_t;

endpackage

### rtl/phrase_match_bracketer_top.sv
`timescale 1ns / 1ps
// An accepted item passes through the input register, then the result register,
// before its first result leaves. Throughput: one item per cycle while each item
// gives at most one result and out_ready is high; an item with n results holds
// the result register until all n have been sent (n up to 10).
// Reset clears the pattern registers, the pending window count and all valids.
// ----------------------------------------------------------------------------
// phrase_match_bracketer_top
// Copies a byte stream and wraps every leftmost, non-overlapping occurrence
// of the configured phrase in parentheses.
// ----------------------------------------------------------------------------
module phrase_match_bracketer_top #(
  parameter int MAX_PHRASE = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [pmb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pmb_pkg::PATTERN_W-1:0]   cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pmb_pkg::BYTE_W-1:0]      text_byte,
  input  logic                            end_of_text,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pmb_pkg::BYTE_W-1:0]      out_byte,
  output logic                            last_of_run
);

  logic [pmb_pkg::PATTERN_W-1:0]           pattern_bytes;
  logic [pmb_pkg::LENGTH_W-1:0]            pattern_length;
  logic                                    in_full;
  logic [pmb_pkg::BYTE_W-1:0]              in_byte;
  logic                                    in_eot;
  logic                                    step;
  logic                                    free;
  logic                                    load;
  logic [MAX_PHRASE+1:0][pmb_pkg::BYTE_W-1:0] burst_bytes;
  logic [$clog2(MAX_PHRASE+3)-1:0]         burst_count;

  assign step     = in_full && free;
  assign in_ready = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= '0;
    end else if (cfg_write_en) begin
      if (cfg_index == pmb_pkg::REG_PATTERN_BYTES) begin
        pattern_bytes <= cfg_data;
      end
      if (cfg_index == pmb_pkg::REG_PATTERN_LENGTH) begin
        pattern_length <= cfg_data[pmb_pkg::LENGTH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= text_byte;
      in_eot  <= end_of_text;
    end
  end

  pmb_scan #(
    .MaxPhrase (MAX_PHRASE)
  ) u_scan (
    .clk            (clk),
    .rst            (rst),
    .clear          (cfg_write_en),
    .pattern_bytes  (pattern_bytes),
    .pattern_length (pattern_length),
    .step           (step),
    .text_byte      (in_byte),
    .end_of_text    (in_eot),
    .load           (load),
    .burst_bytes    (burst_bytes),
    .burst_count    (burst_count)
  );

  pmb_emit #(
    .MaxPhrase (MAX_PHRASE)
  ) u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .burst_bytes (burst_bytes),
    .burst_count (burst_count),
    .free        (free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

### rtl/pmb_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmb_scan
// Holds the pending window and works out, for one item, the bytes to send
// and the window that remains.
// ----------------------------------------------------------------------------
module pmb_scan #(
  parameter int MaxPhrase = 8
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           clear,
  input  logic [pmb_pkg::PATTERN_W-1:0]                  pattern_bytes,
  input  logic [pmb_pkg::LENGTH_W-1:0]                   pattern_length,
  input  logic                                           step,
  input  logic [pmb_pkg::BYTE_W-1:0]                     text_byte,
  input  logic                                           end_of_text,
  output logic                                           load,
  output logic [MaxPhrase+1:0][pmb_pkg::BYTE_W-1:0]      burst_bytes,
  output logic [$clog2(MaxPhrase+3)-1:0]                 burst_count
);

  localparam int WinCntW   = $clog2(MaxPhrase + 1);
  localparam int BurstCntW = $clog2(MaxPhrase + 3);

  logic [pmb_pkg::BYTE_W-1:0] pend [MaxPhrase];
  logic [pmb_pkg::BYTE_W-1:0] pend_next [MaxPhrase];
  logic [WinCntW-1:0]         pend_count;
  logic [WinCntW-1:0]         pend_count_next;

  logic [pmb_pkg::BYTE_W-1:0] win [MaxPhrase];
  logic [pmb_pkg::BYTE_W-1:0] phr [MaxPhrase];
  logic [MaxPhrase:0]         ok;
  logic [WinCntW-1:0]         eff_len;
  logic [WinCntW-1:0]         full;
  logic [WinCntW-1:0]         shift;
  logic                       pass;
  logic                       is_match;

  always_comb begin
    if (int'(pattern_length) > MaxPhrase) begin
      eff_len = WinCntW'(MaxPhrase);
    end else begin
      eff_len = WinCntW'(pattern_length);
    end
    pass = (eff_len == '0);
    full = pend_count + WinCntW'(1);
    for (int k = 0; k < MaxPhrase; k++) begin
      phr[k] = pattern_bytes[pmb_pkg::BYTE_W*k +: pmb_pkg::BYTE_W];
      win[k] = (WinCntW'(k) < pend_count) ? pend[k] : text_byte;
    end
    for (int s = 0; s <= MaxPhrase; s++) begin
      ok[s] = 1'b1;
      for (int j = 0; j < MaxPhrase - s; j++) begin
        if ((s + j) <= int'(pend_count) && win[s+j] != phr[j]) begin
          ok[s] = 1'b0;
        end
      end
    end
    shift = WinCntW'(MaxPhrase);
    for (int s = MaxPhrase; s >= 0; s--) begin
      if (ok[s]) begin
        shift = WinCntW'(s);
      end
    end
    is_match = !pass && (full == eff_len) && ok[0];

    burst_bytes = '0;
    burst_count = '0;
    for (int k = 0; k < MaxPhrase; k++) begin
      pend_next[k] = pend[k];
    end
    pend_count_next = pend_count;

    if (pass) begin
      burst_bytes[0]  = text_byte;
      burst_count     = BurstCntW'(1);
      pend_count_next = '0;
    end else if (is_match) begin
      burst_bytes[0] = pmb_pkg::OPEN_BYTE;
      for (int k = 1; k <= MaxPhrase; k++) begin
        burst_bytes[k] = win[k-1];
      end
      for (int k = 1; k <= MaxPhrase + 1; k++) begin
        if (k == int'(full) + 1) begin
          burst_bytes[k] = pmb_pkg::CLOSE_BYTE;
        end
      end
      burst_count     = BurstCntW'(full) + BurstCntW'(2);
      pend_count_next = '0;
    end else begin
      for (int k = 0; k < MaxPhrase; k++) begin
        burst_bytes[k] = win[k];
      end
      if (end_of_text) begin
        burst_count     = BurstCntW'(full);
        pend_count_next = '0;
      end else begin
        burst_count     = BurstCntW'(shift);
        pend_count_next = full - shift;
        for (int s = 0; s <= MaxPhrase; s++) begin
          if (shift == WinCntW'(s)) begin
            for (int k = 0; k < MaxPhrase; k++) begin
              pend_next[k] = (k + s < MaxPhrase) ? win[(k + s) % MaxPhrase] : win[k];
            end
          end
        end
      end
    end
  end

  assign load = step && (burst_count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_count <= '0;
    end else if (clear) begin
      pend_count <= '0;
    end else if (step) begin
      pend_count <= pend_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int k = 0; k < MaxPhrase; k++) begin
        pend[k] <= pend_next[k];
      end
    end
  end

endmodule

### rtl/pmb_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmb_emit
// Result register that holds the bytes of one item and sends them one per
// cycle while out_ready is high, oldest first.
// ----------------------------------------------------------------------------
module pmb_emit #(
  parameter int MaxPhrase = 8
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      load,
  input  logic [MaxPhrase+1:0][pmb_pkg::BYTE_W-1:0] burst_bytes,
  input  logic [$clog2(MaxPhrase+3)-1:0]            burst_count,
  output logic                                      free,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [pmb_pkg::BYTE_W-1:0]                out_byte,
  output logic                                      last_of_run
);

  localparam int Depth     = MaxPhrase + 2;
  localparam int BurstCntW = $clog2(MaxPhrase + 3);

  logic [Depth-1:0][pmb_pkg::BYTE_W-1:0] data;
  logic [BurstCntW-1:0]                  count;

  assign out_valid   = (count != '0);
  assign out_byte    = data[0];
  assign last_of_run = (count == BurstCntW'(1));
  assign free        = (count == '0) || (last_of_run && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= burst_count;
    end else if (out_valid && out_ready) begin
      count <= count - BurstCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= burst_bytes;
    end else if (out_valid && out_ready) begin
      for (int k = 0; k < Depth - 1; k++) begin
        data[k] <= data[k+1];
      end
    end
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the phrase match bracketer. A directed sequence
// covers pass-through, matches, partial prefixes, flushes, saturated lengths
// and the window discard on a register write. Random phases follow, each with
// its own phrase and length. Each accepted text item is predicted into a queue
// of expected output bytes, and each output item is checked against it. Both
// handshakes idle at random, and the output side holds off once for a long
// stretch.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [pmb_pkg::BYTE_W-1:0] text_byte;
    logic                       end_of_text;
  } text_item_t;

  typedef struct packed {
    logic [pmb_pkg::BYTE_W-1:0] out_byte;
    logic                       last_of_run;
  } bracket_out_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write_en = 1'b0;
  logic [pmb_pkg::CFG_IDX_W-1:0] cfg_index = pmb_pkg::REG_PATTERN_BYTES;
  logic [pmb_pkg::PATTERN_W-1:0] cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [pmb_pkg::BYTE_W-1:0]    text_byte = '0;
  logic                          end_of_text = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [pmb_pkg::BYTE_W-1:0]    out_byte;
  logic                          last_of_run;

  text_item_t   text_queue[$];
  bracket_out_t expected_bytes[$];
  text_item_t   cur_item;
  bracket_out_t want;

  logic [pmb_pkg::PATTERN_W-1:0] phrase_bytes = '0;
  logic [pmb_pkg::LENGTH_W-1:0]  phrase_len = '0;
  logic [pmb_pkg::BYTE_W-1:0]    window[8];
  int                            window_cnt = 0;

  int gap_max = 6;
  int send_gap = 0;
  int recv_stall = 0;
  int recv_count = 0;
  bit long_hold_done = 1'b0;
  int mismatches = 0;
  int cycles = 0;

  always #10 clk = ~clk;

  phrase_match_bracketer_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

  function automatic bit window_matches(int n);
    for (int k = 0; k < n; k++) begin
      if (window[k] != phrase_bytes[8*k +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict_bracketing(input logic [pmb_pkg::BYTE_W-1:0] b, input logic eot);
    int           eff_len;
    logic [7:0]   res[$];
    bracket_out_t r;
    eff_len = (phrase_len > 8) ? 8 : int'(phrase_len);
    if (eff_len == 0) begin
      window_cnt = 0;
      res.insert(res.size(), b);
    end else begin
      if (window_cnt >= eff_len) window_cnt = 0;
      window[window_cnt] = b;
      window_cnt++;
      while (window_cnt > 0) begin
        if (window_cnt == eff_len && window_matches(eff_len)) begin
          res.insert(res.size(), pmb_pkg::OPEN_BYTE);
          for (int k = 0; k < eff_len; k++) res.insert(res.size(), window[k]);
          res.insert(res.size(), pmb_pkg::CLOSE_BYTE);
          window_cnt = 0;
          break;
        end
        if (window_cnt < eff_len && window_matches(window_cnt)) break;
        res.insert(res.size(), window[0]);
        for (int k = 1; k < window_cnt; k++) window[k-1] = window[k];
        window_cnt--;
      end
      if (eot) begin
        for (int k = 0; k < window_cnt; k++) res.insert(res.size(), window[k]);
        window_cnt = 0;
      end
    end
    foreach (res[i]) begin
      r.out_byte = res[i];
      r.last_of_run = (i == res.size() - 1);
      expected_bytes.insert(expected_bytes.size(), r);
    end
  endtask

  function automatic void send_byte(input logic [pmb_pkg::BYTE_W-1:0] b, input logic eot);
    text_item_t t;
    t.text_byte = b;
    t.end_of_text = eot;
    text_queue.insert(text_queue.size(), t);
  endfunction

  task automatic write_reg(input pmb_pkg::cfg_reg_t idx,
                           input logic [pmb_pkg::PATTERN_W-1:0] data);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == pmb_pkg::REG_PATTERN_BYTES) phrase_bytes = data;
    else phrase_len = data[pmb_pkg::LENGTH_W-1:0];
    window_cnt = 0;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic wait_idle();
    while (!(text_queue.size() == 0 && !in_valid && expected_bytes.size() == 0))
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input logic [3:0] len_code, input int n_items, input int gmax,
                              input bit edge_alphabet);
    logic [7:0]  alpha[3];
    logic [63:0] pat;
    logic [63:0] len_data;
    int          eff_len;
    int          sent;
    int          r;
    int          pl;
    for (int k = 0; k < 3; k++) alpha[k] = 8'($urandom);
    if (edge_alphabet) begin
      alpha[0] = 8'h00;
      alpha[1] = 8'hFF;
    end
    pat = {$urandom, $urandom};
    eff_len = (len_code > 8) ? 8 : int'(len_code);
    for (int k = 0; k < eff_len; k++) pat[8*k +: 8] = alpha[$urandom_range(0, 2)];
    len_data = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0;
    len_data[3:0] = len_code;
    gap_max = gmax;
    write_reg(pmb_pkg::REG_PATTERN_BYTES, pat);
    write_reg(pmb_pkg::REG_PATTERN_LENGTH, len_data);
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 9);
      if (eff_len == 0 || r == 9) begin
        send_byte(8'($urandom), $urandom_range(0, 14) == 0);
        sent++;
      end else if (r <= 3) begin
        for (int k = 0; k < eff_len; k++)
          send_byte(pat[8*k +: 8], $urandom_range(0, 14) == 0);
        sent += eff_len;
      end else if (r <= 5 && eff_len > 1) begin
        pl = $urandom_range(1, eff_len - 1);
        for (int k = 0; k < pl; k++) send_byte(pat[8*k +: 8], 1'b0);
        send_byte(alpha[$urandom_range(0, 2)], $urandom_range(0, 14) == 0);
        sent += pl + 1;
      end else begin
        send_byte(alpha[$urandom_range(0, 2)], $urandom_range(0, 14) == 0);
        sent++;
      end
    end
    wait_idle();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) predict_bracketing(text_byte, end_of_text);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (text_queue.size() > 0) begin
          cur_item = text_queue.pop_front();
          text_byte <= cur_item.text_byte;
          end_of_text <= cur_item.end_of_text;
          in_valid <= 1'b1;
          send_gap = $urandom_range(0, gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        recv_count++;
        if (expected_bytes.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected output item: byte %h last %b", out_byte, last_of_run);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.out_byte || last_of_run !== want.last_of_run) begin
            if (mismatches < 10)
              $display("output mismatch: expected byte %h last %b, got byte %h last %b",
                       want.out_byte, want.last_of_run, out_byte, last_of_run);
            mismatches++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready) begin
        if (!long_hold_done && recv_count >= 200) begin
          long_hold_done = 1'b1;
          recv_stall = 400;
        end else begin
          recv_stall = $urandom_range(0, gap_max);
        end
        if (recv_stall > 0) begin
          recv_stall--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("phrase_match_bracketer_top verification failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset state: zero length, so every byte passes straight through.
    gap_max = 6;
    send_byte(8'h00, 1'b0);
    send_byte(pmb_pkg::OPEN_BYTE, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle();

    // Phrase "ab": a match, a failed prefix before a match, and a flush.
    write_reg(pmb_pkg::REG_PATTERN_BYTES, 64'h0000_0000_0000_6261);
    write_reg(pmb_pkg::REG_PATTERN_LENGTH, 64'd2);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'h61, 1'b1);
    wait_idle();

    // Length above the maximum saturates to eight; a full match gives ten bytes.
    gap_max = 0;
    write_reg(pmb_pkg::REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(pmb_pkg::REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int k = 0; k < 8; k++) send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_idle();

    // Waiting bytes are dropped by a register write.
    gap_max = 6;
    write_reg(pmb_pkg::REG_PATTERN_BYTES, 64'h0000_0000_0061_6261);
    write_reg(pmb_pkg::REG_PATTERN_LENGTH, 64'd3);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    wait_idle();
    write_reg(pmb_pkg::REG_PATTERN_LENGTH, 64'd3);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b0);
    wait_idle();

    random_phase(4'd1, 36, 6, 1'b0);
    random_phase(4'd8, 40, 6, 1'b1);
    random_phase(4'd0, 30, 6, 1'b0);
    random_phase(4'd3, 36, 0, 1'b0);
    random_phase(4'd2, 36, 6, 1'b1);
    random_phase(4'd15, 40, 3, 1'b0);
    random_phase(4'd5, 36, 6, 1'b0);
    random_phase(4'd9, 36, 0, 1'b1);
    random_phase(4'd4, 36, 6, 1'b0);
    random_phase(4'd6, 36, 6, 1'b0);
    random_phase(4'd7, 36, 2, 1'b1);
    random_phase(4'd2, 36, 6, 1'b0);

    if (mismatches == 0) begin
      $display("phrase_match_bracketer_top verification clean");
    end else begin
      $display("phrase_match_bracketer_top verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/pmb_pkg.sv
rtl/pmb_scan.sv
rtl/pmb_emit.sv
rtl/phrase_match_bracketer_top.sv
verif/tb_top.sv
